// ===== rtl/cbmt_pkg.sv =====
// Shared constants and types of the sparse-image block map translator.
package cbmt_pkg;

  // Default number of map entries (one flag per image block).
  localparam int MAP_ENTRIES_DEF = 16384;

  // Fixed geometry of one cached group.
  localparam int GROUP_SECTORS = 16;
  localparam int GROUP_BYTES   = 32768;
  localparam int GROUP_WORDS   = GROUP_BYTES / 4;
  localparam int GW_BITS       = $clog2(GROUP_WORDS);

  // A sector holds 512 words of four bytes.
  localparam int SECTOR_WORD_SHIFT = 9;

  // Widths of the configuration registers and of the packed beats.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DAT_W  = 72;
  localparam int OUT_DAT_W = 72;

  // Empty cache tag.
  localparam logic [31:0] NO_GROUP = 32'hFFFF_FFFF;

  // Request kinds carried in tuser; the fourth code is ignored.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_XLATE = 2'd1;
  localparam logic [1:0] REQ_INVAL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_CAP   = 2'd1,
    ST_BEYOND_MAP = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_CALC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

// ===== rtl/cbmt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cbmt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ciso_block_map_translator_core.sv =====
// Top level of the sparse-image block map translator.
//
//   Channel  Direction  Beat contents
//   in_      slave      tuser: req_type; tdata: block_present, word_offset, remaining_bytes
//   out_     master     tdata: fetch_needed .. status, one result beat per input beat
//   cfg_     write      cfg_index selects map_enable, block_shift, data_start_lba, capacity_lba
//
// A load, invalidate or ignored item goes from accept through S_FIN to the result register.
// A translate steps through accept, tag check and map read, base and popcount sum on
// the map read data, and capacity clamp. One item is in flight at a time.
// rst_n is synchronous and active low; the map memory holds no reset state.
// The input is taken while a finished result still waits in the output register;
// the next result waits in the last step until out_tready frees that register.
module ciso_block_map_translator_core
  import cbmt_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input beat: tuser = req_type; tdata = block_present, word_offset, remaining_bytes.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic [IN_DAT_W-1:0]  in_tdata,
  // Result beat: tdata = fetch_needed, physical_lba, sector_count, zero_fill,
  // buffer_offset, chunk_bytes, status.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DAT_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int MAP_GROUPS = (MAP_ENTRIES + 7) / 8;
  localparam int AW         = (MAP_GROUPS > 1) ? $clog2(MAP_GROUPS) : 1;
  localparam int LIW        = $clog2(MAP_ENTRIES + 1);
  localparam int ENT_W      = 40;

  // Input fields.
  logic        in_present;
  logic [31:0] in_woff;
  logic [31:0] in_remain;
  logic        in_accept;

  assign in_present = in_tdata[0];
  assign in_woff    = in_tdata[32:1];
  assign in_remain  = in_tdata[64:33];
  assign in_accept  = in_tvalid && in_tready;

  // Configuration registers.
  logic        map_enable_r;
  logic [4:0]  block_shift_r;
  logic [31:0] data_start_r;
  logic [31:0] capacity_r;

  // Map loading and cache state.
  logic [LIW-1:0] load_index_r, load_index_nxt;
  logic [31:0]    running_lba_r, running_lba_nxt;
  logic [7:0]     presence_acc_r, presence_acc_nxt;
  logic [31:0]    group_base_r, group_base_nxt;
  logic [31:0]    cached_group_r, cached_group_nxt;
  state_t         state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Item and lookup registers.
  logic        trans_r;
  logic [31:0] woff_r;
  logic [31:0] remain_r;
  logic        cap_zero_r;
  logic        hit_r;
  logic        bad_r;
  logic [31:0] group_r;
  logic [2:0]  blk_lo_r;
  logic [14:0] boff_r;
  logic [15:0] chunk_r;
  logic [31:0] plba_r;
  logic [OUT_DAT_W-1:0] out_data_r;

  // Map memory: presence byte over group base.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  cbmt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAP_GROUPS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Load of one map entry: the group base is taken at the first entry of each group.
  logic       ld_room;
  logic [2:0] ld_bit;
  logic       ld_first;
  logic [7:0] ld_acc;
  logic [31:0] ld_base;
  logic [31:0] ld_step;

  always_comb begin
    ld_room  = load_index_r < LIW'(MAP_ENTRIES);
    ld_bit   = load_index_r[2:0];
    ld_first = (ld_bit == 3'd0);
    ld_acc   = (ld_first ? 8'h00 : presence_acc_r) | (8'(in_present) << ld_bit);
    ld_base  = ld_first ? running_lba_r : group_base_r;
    ld_step  = in_present ? (32'd1 << block_shift_r) : 32'd0;
  end

  assign ram_we    = in_accept && (in_tuser == REQ_LOAD) && ld_room;
  assign ram_waddr = AW'(load_index_r >> 3);
  assign ram_wdata = {ld_acc, ld_base};

  // Tag check on the registered request.
  logic [31:0] lk_lba;
  logic [31:0] lk_group;
  logic [31:0] lk_blk;
  logic        lk_hit;
  logic        lk_bad;
  logic        lk_cap_zero;
  logic [14:0] lk_boff;
  logic [16:0] lk_room;
  logic [15:0] lk_chunk;

  always_comb begin
    lk_lba      = woff_r >> SECTOR_WORD_SHIFT;
    lk_group    = lk_lba & ~32'(GROUP_SECTORS - 1);
    lk_blk      = lk_group >> block_shift_r;
    lk_hit      = (lk_group == cached_group_r);
    // The map range is only checked for a group that misses the cache tag.
    lk_bad      = map_enable_r && !lk_hit && (lk_blk >= 32'(MAP_ENTRIES));
    lk_cap_zero = (capacity_r == 32'd0);
    lk_boff     = {woff_r[GW_BITS-1:0], 2'b00};
    lk_room     = 17'(GROUP_BYTES) - {2'b00, lk_boff};
    lk_chunk    = (32'(lk_room) > remain_r) ? remain_r[15:0] : lk_room[15:0];
  end

  assign ram_re    = (state_r == S_LOOK);
  assign ram_raddr = AW'(lk_blk >> 3);

  // Physical LBA: with the map enabled, base plus earlier present blocks plus offset; else the group LBA.
  logic [7:0]  cl_below;
  logic [3:0]  cl_pop;
  logic [31:0] cl_mask;
  logic [31:0] cl_plba;

  always_comb begin
    cl_below = (8'd1 << blk_lo_r) - 8'd1;
    cl_pop   = 4'($countones(ram_rdata[39:32] & cl_below));
    cl_mask  = ~(32'hFFFF_FFFF << block_shift_r);
    if (map_enable_r) begin
      cl_plba = ram_rdata[31:0] + (32'(cl_pop) << block_shift_r) + (group_r & cl_mask);
    end else begin
      cl_plba = group_r;
    end
  end

  // Capacity clamp and result assembly.
  logic [31:0] fn_room;
  logic [4:0]  fn_count;
  logic        fn_zfill;
  logic        fn_fetch;
  logic [31:0] fn_plba;
  logic [4:0]  fn_cnt_out;
  logic        fn_zf_out;
  logic [14:0] fn_boff;
  logic [15:0] fn_chunk;
  status_t     fn_status;
  logic        fn_free;

  always_comb begin
    fn_room = capacity_r - plba_r;
    if (plba_r >= capacity_r) begin
      fn_count = 5'd0;
    end else if (fn_room > 32'(GROUP_SECTORS)) begin
      fn_count = 5'(GROUP_SECTORS);
    end else begin
      fn_count = fn_room[4:0];
    end
    fn_zfill   = fn_count < 5'(GROUP_SECTORS);
    fn_fetch   = 1'b0;
    fn_plba    = 32'd0;
    fn_cnt_out = 5'd0;
    fn_zf_out  = 1'b0;
    fn_boff    = 15'd0;
    fn_chunk   = 16'd0;
    fn_status  = ST_OK;
    if (trans_r) begin
      if (cap_zero_r) begin
        fn_status = ST_ZERO_CAP;
      end else if (bad_r) begin
        fn_status = ST_BEYOND_MAP;
      end else begin
        fn_boff  = boff_r;
        fn_chunk = chunk_r;
        if (!hit_r) begin
          fn_fetch   = 1'b1;
          fn_plba    = plba_r;
          fn_cnt_out = fn_count;
          fn_zf_out  = fn_zfill;
        end
      end
    end
    fn_free = !out_valid_r || out_tready;
  end

  // Sequencer and control state.
  always_comb begin
    state_nxt        = state_r;
    load_index_nxt   = load_index_r;
    running_lba_nxt  = running_lba_r;
    presence_acc_nxt = presence_acc_r;
    group_base_nxt   = group_base_r;
    cached_group_nxt = cached_group_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_tuser == REQ_XLATE) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_FIN;
          end
          if (ram_we) begin
            load_index_nxt   = load_index_r + LIW'(1);
            running_lba_nxt  = running_lba_r + ld_step;
            presence_acc_nxt = ld_acc;
            group_base_nxt   = ld_base;
          end
          if (in_tuser == REQ_INVAL) begin
            load_index_nxt   = '0;
            running_lba_nxt  = data_start_r;
            presence_acc_nxt = 8'h00;
            cached_group_nxt = NO_GROUP;
          end
        end
      end
      S_LOOK: begin
        state_nxt = S_CALC;
        if (lk_cap_zero || lk_bad) begin
          cached_group_nxt = NO_GROUP;
        end else begin
          cached_group_nxt = lk_group;
        end
      end
      S_CALC: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fn_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      load_index_r   <= '0;
      running_lba_r  <= 32'd16;
      presence_acc_r <= 8'h00;
      cached_group_r <= NO_GROUP;
      map_enable_r   <= 1'b0;
      block_shift_r  <= 5'd10;
      data_start_r   <= 32'd16;
      capacity_r     <= 32'd0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      load_index_r   <= load_index_nxt;
      running_lba_r  <= running_lba_nxt;
      presence_acc_r <= presence_acc_nxt;
      cached_group_r <= cached_group_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAP_ENABLE:  map_enable_r  <= cfg_wdata[0];
          REG_BLOCK_SHIFT: block_shift_r <= cfg_wdata[4:0];
          REG_DATA_START:  data_start_r  <= cfg_wdata;
          REG_CAPACITY:    capacity_r    <= cfg_wdata;
          default:         map_enable_r  <= map_enable_r;
        endcase
      end
    end
  end

  // Payload registers of the item in flight and of the result.
  always_ff @(posedge clk) begin
    group_base_r <= group_base_nxt;
    if (in_accept) begin
      trans_r  <= (in_tuser == REQ_XLATE);
      woff_r   <= in_woff;
      remain_r <= in_remain;
    end
    if (state_r == S_LOOK) begin
      cap_zero_r <= lk_cap_zero;
      hit_r      <= lk_hit;
      bad_r      <= lk_bad;
      group_r    <= lk_group;
      blk_lo_r   <= lk_blk[2:0];
      boff_r     <= lk_boff;
      chunk_r    <= lk_chunk;
    end
    if (state_r == S_CALC) begin
      plba_r <= cl_plba;
    end
    if (state_r == S_FIN && fn_free) begin
      out_data_r <= {fn_status, fn_chunk, fn_boff, fn_zf_out, fn_cnt_out, fn_plba, fn_fetch};
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A load write never meets a map read in the same cycle.
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("map memory written and read in the same cycle");

  // The load index never passes the number of map entries.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_index_r <= LIW'(MAP_ENTRIES))
    else $error("load index beyond map size");

  // A zero-capacity result carries nothing but its status.
  a_zero_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r[71:70] == ST_ZERO_CAP) |-> (out_data_r[69:0] == 70'd0))
    else $error("zero-capacity result has nonzero fields");

  // On a fetch the zero-fill flag follows a short sector count.
  a_fetch_zfill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |->
      (out_data_r[38] == (out_data_r[37:33] < 5'(GROUP_SECTORS))) &&
      (out_data_r[37:33] <= 5'(GROUP_SECTORS)))
    else $error("fetch result with inconsistent sector count");
`endif

endmodule
